>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked on clk_i, quiet while rst_ni is low
`define JMDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// clocked on clk_i, also checked during reset
`define JMDR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define JMDR_ASSERT(lbl, prop, msg)
`define JMDR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> design/jmdr_pkg.sv
// ----------------------------------------------------------------------------
// jmdr_pkg
// Types and codes shared by the anti-diagonal reorder store.
// ----------------------------------------------------------------------------
package jmdr_pkg;

  localparam logic ActLoad  = 1'b0;
  localparam logic ActFetch = 1'b1;

  localparam int unsigned ValueW = 32;

  typedef struct packed {
    logic                     action;
    logic [5:0]               row;
    logic [5:0]               col;
    logic signed [ValueW-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [ValueW-1:0] out_value;
    logic                     is_last;
    logic                     is_empty;
  } out_t;

endpackage

>>> design/jagged_matrix_diagonal_reorder.sv
// ----------------------------------------------------------------------------
// jagged_matrix_diagonal_reorder
// Sparse MAX_ROWS x MAX_COLS store read back in anti-diagonal order.
// ----------------------------------------------------------------------------
// After reset the block sweeps its cell memory once to clear every valid
// flag, one cell a cycle, with in_ready_o low until the sweep is done. A
// load reads the old cell, then writes the new one. A fetch walks cells
// from the scan cursor through one shared step unit and the single read
// port of the cell memory, one cell a cycle; an empty store skips the walk.
// The result waits in an output register; the next item is taken once the
// result has entered it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jagged_matrix_diagonal_reorder #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  jmdr_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output jmdr_pkg::out_t out_data_o
);

  localparam int unsigned NCells = MAX_ROWS * MAX_COLS;
  localparam int unsigned NDiag  = MAX_ROWS + MAX_COLS - 1;
  localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CLW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned DW  = (NDiag > 1) ? $clog2(NDiag) : 1;
  localparam int unsigned AW  = (NCells > 1) ? $clog2(NCells) : 1;
  localparam int unsigned CW  = $clog2(NCells + 1);
  localparam int unsigned MW  = jmdr_pkg::ValueW + 1;

  localparam logic [DW-1:0] TopLim  = DW'(MAX_ROWS - 1);
  localparam logic [DW-1:0] ColLim  = DW'(MAX_COLS - 1);
  localparam logic [DW-1:0] LastD   = DW'(NDiag - 1);
  localparam logic [AW-1:0] ColsA   = AW'(MAX_COLS);
  localparam logic [AW-1:0] LastA   = AW'(NCells - 1);
  localparam logic [CW-1:0] CountMx = CW'(NCells);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LDWR = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  function automatic logic [RW-1:0] top_row(logic [DW-1:0] d);
    top_row = (d < TopLim) ? RW'(d) : RW'(TopLim);
  endfunction

  function automatic logic [RW-1:0] low_row(logic [DW-1:0] d);
    low_row = (d > ColLim) ? RW'(d - ColLim) : '0;
  endfunction

  function automatic logic [AW-1:0] addr_of(logic [RW-1:0] r, logic [CLW-1:0] c);
    addr_of = AW'(r) * ColsA + AW'(c);
  endfunction

  logic [2:0]      state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [CW-1:0]   count_q, count_d;
  logic [DW-1:0]   scan_d_q, scan_d_d;
  logic [RW-1:0]   scan_r_q, scan_r_d;

  logic [AW-1:0]   ld_addr_q, ld_addr_d;
  logic [RW-1:0]   ld_r_q, ld_r_d;
  logic [CLW-1:0]  ld_c_q, ld_c_d;
  logic [jmdr_pkg::ValueW-1:0] ld_val_q, ld_val_d;

  logic [DW-1:0]   cur_d_q, cur_d_d;
  logic [RW-1:0]   cur_r_q, cur_r_d;
  logic [CLW-1:0]  cur_c_q, cur_c_d;
  logic [DW-1:0]   chk_d_q, chk_d_d;
  logic [RW-1:0]   chk_r_q, chk_r_d;
  logic [AW-1:0]   chk_a_q, chk_a_d;
  logic            chk_vld_q, chk_vld_d;
  logic            chk_last_q, chk_last_d;

  jmdr_pkg::out_t  res_q, res_d;
  jmdr_pkg::out_t  out_q, out_d;
  logic            out_vld_q, out_vld_d;

  logic [MW-1:0]   mem [NCells];
  logic [MW-1:0]   rd_q;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [MW-1:0]   wdata;

  logic            in_fire, row_ok, col_ok;
  logic [RW-1:0]   in_r, st_top, st_r, cur_low, nx_top;
  logic [CLW-1:0]  in_c;
  logic [DW-1:0]   ld_diag, nx_diag;
  logic            at_low, last_pos, hit;
  logic [AW-1:0]   cur_addr;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign row_ok   = ({26'd0, in_data_i.row} < 32'(MAX_ROWS));
  assign col_ok   = ({26'd0, in_data_i.col} < 32'(MAX_COLS));
  assign in_r     = RW'(in_data_i.row);
  assign in_c     = CLW'(in_data_i.col);
  assign ld_diag  = DW'(ld_r_q) + DW'(ld_c_q);

  assign st_top   = top_row(scan_d_q);
  assign st_r     = (scan_r_q < st_top) ? scan_r_q : st_top;

  // scan step unit
  assign cur_low  = low_row(cur_d_q);
  assign at_low   = (cur_r_q <= cur_low);
  assign last_pos = at_low && (cur_d_q == LastD);
  assign nx_diag  = cur_d_q + DW'(1);
  assign nx_top   = top_row(nx_diag);
  assign cur_addr = addr_of(cur_r_q, cur_c_q);
  assign hit      = (state_q == S_SCAN) && chk_vld_q && rd_q[MW-1];

  assign raddr = (state_q == S_IDLE) ? addr_of(in_r, in_c) : cur_addr;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    count_d    = count_q;
    scan_d_d   = scan_d_q;
    scan_r_d   = scan_r_q;
    ld_addr_d  = ld_addr_q;
    ld_r_d     = ld_r_q;
    ld_c_d     = ld_c_q;
    ld_val_d   = ld_val_q;
    cur_d_d    = cur_d_q;
    cur_r_d    = cur_r_q;
    cur_c_d    = cur_c_q;
    chk_d_d    = chk_d_q;
    chk_r_d    = chk_r_q;
    chk_a_d    = chk_a_q;
    chk_vld_d  = chk_vld_q;
    chk_last_d = chk_last_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    we         = 1'b0;
    waddr      = chk_a_q;
    wdata      = {1'b0, rd_q[MW-2:0]};

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + AW'(1);
        if (clr_q == LastA) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_data_i.action == jmdr_pkg::ActLoad) begin
            if (row_ok && col_ok) begin
              ld_addr_d = addr_of(in_r, in_c);
              ld_r_d    = in_r;
              ld_c_d    = in_c;
              ld_val_d  = in_data_i.value;
              state_d   = S_LDWR;
            end
          end else if (count_q != '0) begin
            cur_d_d   = scan_d_q;
            cur_r_d   = st_r;
            cur_c_d   = CLW'(scan_d_q - DW'(st_r));
            chk_vld_d = 1'b0;
            state_d   = S_SCAN;
          end else begin
            scan_d_d = '0;
            scan_r_d = '0;
            res_d    = '{out_value: '0, is_last: 1'b0, is_empty: 1'b1};
            state_d  = S_EMIT;
          end
        end
      end
      S_LDWR: begin
        we    = 1'b1;
        waddr = ld_addr_q;
        wdata = {1'b1, ld_val_q};
        if (!rd_q[MW-1]) begin
          count_d = count_q + CW'(1);
        end
        if (ld_diag < scan_d_q || (ld_diag == scan_d_q && ld_r_q > scan_r_q)) begin
          scan_d_d = ld_diag;
          scan_r_d = ld_r_q;
        end
        state_d = S_IDLE;
      end
      S_SCAN: begin
        if (hit) begin
          we       = 1'b1;
          count_d  = count_q - CW'(1);
          scan_d_d = chk_d_q;
          scan_r_d = chk_r_q;
          res_d    = '{out_value: rd_q[MW-2:0], is_last: (count_q == CW'(1)),
                       is_empty: 1'b0};
          state_d  = S_EMIT;
        end else if (chk_vld_q && chk_last_q) begin
          count_d  = '0;
          scan_d_d = '0;
          scan_r_d = '0;
          res_d    = '{out_value: '0, is_last: 1'b0, is_empty: 1'b1};
          state_d  = S_EMIT;
        end else begin
          chk_d_d    = cur_d_q;
          chk_r_d    = cur_r_q;
          chk_a_d    = cur_addr;
          chk_vld_d  = 1'b1;
          chk_last_d = last_pos;
          if (!last_pos) begin
            if (!at_low) begin
              cur_r_d = cur_r_q - RW'(1);
              cur_c_d = cur_c_q + CLW'(1);
            end else begin
              cur_d_d = nx_diag;
              cur_r_d = nx_top;
              cur_c_d = CLW'(nx_diag - DW'(nx_top));
            end
          end
        end
      end
      S_EMIT: begin
        if (!out_vld_q || out_ready_i) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      clr_q      <= '0;
      count_q    <= '0;
      scan_d_q   <= '0;
      scan_r_q   <= '0;
      chk_vld_q  <= 1'b0;
      chk_last_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      count_q    <= count_d;
      scan_d_q   <= scan_d_d;
      scan_r_q   <= scan_r_d;
      chk_vld_q  <= chk_vld_d;
      chk_last_q <= chk_last_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_addr_q <= ld_addr_d;
    ld_r_q    <= ld_r_d;
    ld_c_q    <= ld_c_d;
    ld_val_q  <= ld_val_d;
    cur_d_q   <= cur_d_d;
    cur_r_q   <= cur_r_d;
    cur_c_q   <= cur_c_d;
    chk_d_q   <= chk_d_d;
    chk_r_q   <= chk_r_d;
    chk_a_q   <= chk_a_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // cell memory: valid flag on top of the value
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  `JMDR_ASSERT(a_count_bound, count_q <= CountMx, "stored count beyond store size")
  `JMDR_ASSERT(a_hit_nonempty, hit |-> count_q != '0, "cell found with zero count")
  `JMDR_ASSERT(a_fetch_starts,
    in_fire && in_data_i.action == jmdr_pkg::ActFetch |=> state_q == S_SCAN || state_q == S_EMIT,
    "fetch transfer did not start a scan")
  `JMDR_ASSERT(a_empty_result,
    out_vld_q && out_q.is_empty |-> !out_q.is_last && out_q.out_value == '0,
    "malformed empty result")
  `JMDR_ASSERT_ALWAYS(a_no_ready_in_reset, !rst_ni |-> !in_ready_o,
    "ready during reset")

endmodule
